// ----- rtl/cfa_pkg.sv -----
// Shared types, codes and defaults for the contiguous fit allocator.
// Used by cfa_cell and contiguous_fit_allocator_top; no dependencies.
package cfa_pkg;

  localparam int SIZE_W           = 17;
  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_ADDR_BITS    = 16;
  localparam logic [SIZE_W-1:0] RESET_MEM_SIZE = 17'd65536;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  localparam logic [1:0] ST_GRANT   = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOFIT   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic REG_FIT_MODE = 1'b0;
  localparam logic REG_MEM_SIZE = 1'b1;

  // fixed-width part of a segment entry (start travels separately)
  typedef struct packed {
    logic              used;
    logic              free;
    logic [SIZE_W-1:0] size;
  } seg_t;

  // fixed-width part of the search token
  typedef struct packed {
    logic              active;
    logic              found;
    logic [SIZE_W-1:0] size;
  } tok_t;

  // broadcast command to all cells
  typedef struct packed {
    logic              init;
    logic              take;
    logic              split;
    logic [1:0]        mode;
    logic [SIZE_W-1:0] req;
    logic [SIZE_W-1:0] init_size;
    logic [SIZE_W-1:0] new_size;
  } cmd_t;

endpackage

// ----- rtl/contiguous_fit_allocator_top.sv -----
// Top level of the contiguous fit allocator: control, id counter, cell row.
// Depends on cfa_pkg and cfa_cell.
//
//   port group        dir  handshake          payload
//   request           in   in_valid/in_stall  request_size
//   result            out  out_valid/out_stall status, block_id
//   config            in   cfg_write_en       cfg_index, cfg_data
//
// For an item a search token walks the row of cells one cell a cycle; when it
// comes out of the last cell the take or split is applied (the split shifts
// all later cells up at once) and the result register loads in the same cycle.
// An invalid size skips the search. Reset is synchronous and gives one free
// segment of 65536 units. in_stall is high while an item is in work or its
// result waits; the result holds until out_stall is low.
module contiguous_fit_allocator_top
  import cfa_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SIZE_W-1:0] request_size,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [SIZE_W-1:0] block_id,
  input  logic              cfg_write_en,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam longint CAP = (ADDR_BITS < SIZE_W) ? (64'd1 << ADDR_BITS) : 64'd131071;
  localparam logic [SIZE_W-1:0] CAP_SIZE = SIZE_W'(CAP);
  localparam logic [SIZE_W-1:0] RST_SIZE =
    (RESET_MEM_SIZE > CAP_SIZE) ? CAP_SIZE : RESET_MEM_SIZE;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state, state_next;
  logic [1:0]        fit_mode;
  logic [SIZE_W-1:0] mem_limit, req, next_id, id_inc, cfg_size;
  logic [CW-1:0]     seg_count;
  logic              accept, done, do_take, do_split, bad;
  cmd_t              cmd;
  logic [IW-1:0]     pick;
  logic [ADDR_BITS-1:0] new_start;

  seg_t                 segs   [MAX_SEGMENTS];
  logic [ADDR_BITS-1:0] starts [MAX_SEGMENTS];
  tok_t                 toks   [MAX_SEGMENTS+1];
  logic [IW-1:0]        tpicks [MAX_SEGMENTS+1];
  logic [ADDR_BITS-1:0] tstart [MAX_SEGMENTS+1];

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign bad      = (request_size == '0) || (request_size > mem_limit);
  assign cfg_size = (cfg_data > CAP_SIZE) ? CAP_SIZE : cfg_data;

  // token end of row
  assign done     = (state == S_SCAN) && toks[MAX_SEGMENTS].active;
  assign pick     = tpicks[MAX_SEGMENTS];
  assign do_take  = done && toks[MAX_SEGMENTS].found && toks[MAX_SEGMENTS].size == req;
  assign do_split = done && toks[MAX_SEGMENTS].found && toks[MAX_SEGMENTS].size != req
                 && seg_count < MAX_CNT;
  assign new_start = tstart[MAX_SEGMENTS] + ADDR_BITS'(req);

  assign id_inc = next_id + 1'b1;

  always_comb begin
    cmd.init      = cfg_write_en && cfg_index == REG_MEM_SIZE;
    cmd.init_size = cfg_size;
    cmd.take      = do_take;
    cmd.split     = do_split;
    cmd.mode      = fit_mode;
    // cell 0 sees the token in the accept cycle, before req is loaded
    cmd.req       = accept ? request_size : req;
    cmd.new_size  = toks[MAX_SEGMENTS].size - req;
  end

  // token injection at the head of the row
  assign toks[0].active = accept && !bad;
  assign toks[0].found  = 1'b0;
  assign toks[0].size   = '0;
  assign tpicks[0]      = '0;
  assign tstart[0]      = '0;

  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    seg_t                 lseg;
    logic [ADDR_BITS-1:0] lstart;
    if (k == 0) begin : g_head
      assign lseg   = '0;
      assign lstart = '0;
    end else begin : g_body
      assign lseg   = segs[k-1];
      assign lstart = starts[k-1];
    end
    cfa_cell #(
      .IDX(k), .IW(IW), .ADDR_BITS(ADDR_BITS), .RST_SIZE(RST_SIZE)
    ) u_cell (
      .clk(clk), .rst(rst), .cmd(cmd), .pick(pick), .new_start(new_start),
      .left_seg(lseg), .left_start(lstart), .seg(segs[k]), .start(starts[k]),
      .tok_in(toks[k]), .tok_in_pick(tpicks[k]), .tok_in_start(tstart[k]),
      .tok_out(toks[k+1]), .tok_out_pick(tpicks[k+1]), .tok_out_start(tstart[k+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = bad ? S_OUT : S_SCAN;
      S_SCAN: if (done) state_next = S_OUT;
      S_OUT:  if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fit_mode    <= MODE_FIRST;
      mem_limit   <= RST_SIZE;
      seg_count   <= CW'(1);
      next_id     <= SIZE_W'(1);
    end else begin
      state <= state_next;
      if (cfg_write_en && cfg_index == REG_FIT_MODE) begin
        fit_mode <= cfg_data[1:0];
      end
      if (cmd.init) begin
        mem_limit   <= cfg_size;
        seg_count   <= CW'(1);
        next_id     <= SIZE_W'(1);
      end else if (do_take || do_split) begin
        next_id <= (id_inc == '0) ? SIZE_W'(1) : id_inc;
        if (do_split) begin
          seg_count <= seg_count + 1'b1;
        end
      end
    end
  end

  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (accept) begin
      req      <= request_size;
      status   <= bad ? ST_INVALID : ST_GRANT;
      block_id <= '0;
    end else if (done) begin
      if (do_take || do_split) begin
        status   <= ST_GRANT;
        block_id <= next_id;
      end else begin
        status   <= toks[MAX_SEGMENTS].found ? ST_FULL : ST_NOFIT;
        block_id <= '0;
      end
    end
  end

endmodule

// ----- rtl/cfa_cell.sv -----
// One table entry of the allocator plus one stage of the search token line.
// Depends on cfa_pkg.
module cfa_cell
  import cfa_pkg::*;
#(
  parameter int IDX       = 0,
  parameter int IW        = 6,
  parameter int ADDR_BITS = DEF_ADDR_BITS,
  parameter logic [SIZE_W-1:0] RST_SIZE = RESET_MEM_SIZE
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic [IW-1:0]        pick,
  input  logic [ADDR_BITS-1:0] new_start,
  input  seg_t                 left_seg,
  input  logic [ADDR_BITS-1:0] left_start,
  output seg_t                 seg,
  output logic [ADDR_BITS-1:0] start,
  input  tok_t                 tok_in,
  input  logic [IW-1:0]        tok_in_pick,
  input  logic [ADDR_BITS-1:0] tok_in_start,
  output tok_t                 tok_out,
  output logic [IW-1:0]        tok_out_pick,
  output logic [ADDR_BITS-1:0] tok_out_start
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic hit, better;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg.used <= (IDX == 0);
      seg.free <= (IDX == 0);
      seg.size <= (IDX == 0) ? RST_SIZE : '0;
      start    <= '0;
    end else if (cmd.init) begin
      seg.used <= (IDX == 0);
      seg.free <= (IDX == 0);
      seg.size <= (IDX == 0) ? cmd.init_size : '0;
      start    <= '0;
    end else if (cmd.take && pick == MY_IDX) begin
      seg.free <= 1'b0;
    end else if (cmd.split) begin
      if (pick == MY_IDX) begin
        seg.size <= cmd.req;
        seg.free <= 1'b0;
      end else if (int'(pick) + 1 == IDX) begin
        seg.used <= 1'b1;
        seg.free <= 1'b1;
        seg.size <= cmd.new_size;
        start    <= new_start;
      end else if (int'(pick) + 1 < IDX) begin
        // open a slot: entries past the split move up one place
        seg   <= left_seg;
        start <= left_start;
      end
    end
  end

  assign hit = tok_in.active && seg.used && seg.free && (seg.size >= cmd.req);
  assign better = !tok_in.found
               || (cmd.mode == MODE_BEST  && seg.size < tok_in.size)
               || (cmd.mode == MODE_WORST && seg.size > tok_in.size);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_in.active;
    end
  end

  always_ff @(posedge clk) begin
    if (hit && better) begin
      tok_out.found <= 1'b1;
      tok_out.size  <= seg.size;
      tok_out_pick  <= MY_IDX;
      tok_out_start <= start;
    end else begin
      tok_out.found <= tok_in.found;
      tok_out.size  <= tok_in.size;
      tok_out_pick  <= tok_in_pick;
      tok_out_start <= tok_in_start;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Self-checking bench for contiguous_fit_allocator_top: segment-table predictor,
// directed and random allocation sequences, randomized valid/stall gaps.
// Depends on cfa_pkg and the RTL top.
`timescale 1ns / 100ps

module tb_top;
  import cfa_pkg::*;

  localparam int NSEG = 64;
  localparam int ABITS = 16;

  typedef struct packed {
    logic [1:0]        st;
    logic [SIZE_W-1:0] id;
  } alloc_res_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [SIZE_W-1:0] request_size = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        status;
  logic [SIZE_W-1:0] block_id;
  logic              cfg_write_en = 1'b0;
  logic              cfg_index = REG_FIT_MODE;
  logic [SIZE_W-1:0] cfg_data = '0;

  contiguous_fit_allocator_top u_top (.*);

  // predictor state
  logic [1:0]        fit_sel;
  logic [SIZE_W-1:0] mem_total;
  logic [SIZE_W-1:0] tbl_size [NSEG];
  logic              tbl_free [NSEG];
  int                tbl_count;
  logic [SIZE_W-1:0] id_next;

  alloc_res_t grant_q[$];
  int mismatches = 0;
  int results_seen = 0;
  bit stall_heavy = 0;

  initial forever #10 clk = ~clk;

  function automatic void table_reinit(logic [SIZE_W-1:0] total);
    if (total > SIZE_W'(1 << ABITS)) total = SIZE_W'(1 << ABITS);
    mem_total = total;
    for (int k = 0; k < NSEG; k++) begin
      tbl_size[k] = '0;
      tbl_free[k] = 1'b0;
    end
    tbl_size[0] = total;
    tbl_free[0] = 1'b1;
    tbl_count = 1;
    id_next = SIZE_W'(1);
  endfunction

  function automatic logic [SIZE_W-1:0] issue_id();
    logic [SIZE_W-1:0] id;
    id = id_next;
    id_next = id_next + 1'b1;
    if (id_next == 0) id_next = SIZE_W'(1);
    return id;
  endfunction

  function automatic alloc_res_t predict_alloc(logic [SIZE_W-1:0] sz);
    alloc_res_t r;
    int pick;
    bit found;
    pick = 0;
    found = 0;
    r = '{st: ST_GRANT, id: '0};
    if (sz == 0 || sz > mem_total) begin
      r.st = ST_INVALID;
      return r;
    end
    for (int k = 0; k < tbl_count; k++) begin
      if (!tbl_free[k] || tbl_size[k] < sz) continue;
      if (!found) begin
        found = 1;
        pick = k;
        if (fit_sel != MODE_BEST && fit_sel != MODE_WORST) break;
      end else if (fit_sel == MODE_BEST && tbl_size[k] < tbl_size[pick]) begin
        pick = k;
      end else if (fit_sel == MODE_WORST && tbl_size[k] > tbl_size[pick]) begin
        pick = k;
      end
    end
    if (!found) begin
      r.st = ST_NOFIT;
      return r;
    end
    if (tbl_size[pick] == sz) begin
      tbl_free[pick] = 1'b0;
      r.id = issue_id();
      return r;
    end
    if (tbl_count >= NSEG) begin
      r.st = ST_FULL;
      return r;
    end
    for (int k = tbl_count; k > pick + 1; k--) begin
      tbl_size[k] = tbl_size[k-1];
      tbl_free[k] = tbl_free[k-1];
    end
    tbl_size[pick+1] = tbl_size[pick] - sz;
    tbl_free[pick+1] = 1'b1;
    tbl_count++;
    tbl_size[pick] = sz;
    tbl_free[pick] = 1'b0;
    r.id = issue_id();
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // valid drops between items, then a random gap follows
  task automatic send_request(logic [SIZE_W-1:0] sz);
    repeat (gap_len() + 1) @(posedge clk);
    in_valid <= 1'b1;
    request_size <= sz;
    do @(posedge clk); while (in_stall);
    grant_q.push_back(predict_alloc(sz));
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (grant_q.size() != 0) @(posedge clk);
    repeat (NSEG + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [SIZE_W-1:0] val);
    drain();
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == REG_FIT_MODE) fit_sel = val[1:0];
    else table_reinit(val);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      alloc_res_t e;
      results_seen++;
      if (grant_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: status %0d id %0d", status, block_id);
      end else begin
        e = grant_q.pop_front();
        if (e.st !== status || e.id !== block_id) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp status %0d id %0d, got status %0d id %0d",
                     e.st, e.id, status, block_id);
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    int p;
    p = $urandom_range(0, 99);
    if (rst) out_stall <= 1'b0;
    else if (stall_heavy) out_stall <= (p < 70);
    else out_stall <= (p < 20);
  end

  task automatic test_directed();
    write_reg(REG_FIT_MODE, SIZE_W'(MODE_FIRST));
    send_request(17'd0);
    send_request(17'd65537);
    send_request(17'h1FFFF);
    send_request(17'd65536);          // exact fit of whole memory
    send_request(17'd1);              // nothing free
    write_reg(REG_MEM_SIZE, 17'h1FFFF); // saturates
    send_request(17'd65536);
    write_reg(REG_MEM_SIZE, 17'd0);
    send_request(17'd1);
    write_reg(REG_MEM_SIZE, 17'd1);
    send_request(17'd1);
    send_request(17'd1);
    write_reg(REG_MEM_SIZE, 17'd100);
    send_request(17'd10); send_request(17'd20); send_request(17'd30); send_request(17'd40);
    write_reg(REG_FIT_MODE, SIZE_W'(2'd3)); // unused mode acts as first fit
    send_request(17'd5);
    write_reg(REG_FIT_MODE, SIZE_W'(MODE_BEST));
    send_request(17'd3);
    write_reg(REG_FIT_MODE, SIZE_W'(MODE_WORST));
    send_request(17'd2);
  endtask

  // fill the table until splits fail, then exact fits still grant
  task automatic test_table_full();
    write_reg(REG_MEM_SIZE, 17'd200);
    write_reg(REG_FIT_MODE, SIZE_W'(MODE_FIRST));
    for (int k = 0; k < 66; k++) send_request(17'd1);
    send_request(17'd137);
    send_request(17'd2);
  endtask

  task automatic test_random(int n);
    int k;
    k = 0;
    while (k < n) begin
      logic [SIZE_W-1:0] msz;
      logic [SIZE_W-1:0] sz;
      int p;
      p = $urandom_range(0, 9);
      msz = (p == 0) ? 17'd65536 : (p < 3) ? SIZE_W'($urandom_range(1, 17'h1FFFF))
                                           : SIZE_W'($urandom_range(1, 4000));
      write_reg(REG_MEM_SIZE, msz);
      write_reg(REG_FIT_MODE, SIZE_W'($urandom_range(0, 3)));
      stall_heavy = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(20, 90)) begin
        p = $urandom_range(0, 99);
        if (p < 5) sz = '0;
        else if (p < 8) sz = SIZE_W'($urandom_range(0, 17'h1FFFF));
        else if (p < 13) sz = mem_total + SIZE_W'($urandom_range(0, 3));
        else if (p < 20 && tbl_count > 0) sz = tbl_size[$urandom_range(0, tbl_count-1)];
        else sz = SIZE_W'($urandom_range(1, (mem_total / 16) + 1));
        send_request(sz);
        k++;
      end
      if ($urandom_range(0, 4) == 0) drain();
    end
    stall_heavy = 0;
  endtask

  initial begin
    table_reinit(RESET_MEM_SIZE);
    fit_sel = MODE_FIRST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(1750);
    drain();
    if (mismatches == 0 && grant_q.size() == 0)
      $display("contiguous_fit_allocator_top regression: pass");
    else
      $display("contiguous_fit_allocator_top regression: fail");
    $finish;
  end

  initial begin
    #40ms;
    $display("contiguous_fit_allocator_top regression: fail");
    $finish;
  end

endmodule
